@@ src/nase_pkg.sv @@
`default_nettype none

package nase_pkg;

    localparam int LANE_W      = 16;
    localparam int CHUNK       = 32;
    localparam int CHUNK_SHIFT = $clog2(CHUNK);

    typedef logic [LANE_W-1:0] lane_t;
    typedef lane_t [CHUNK-1:0] row_t;

    localparam logic [3:0] MODE_LOAD_WEIGHT = 4'd0;
    localparam logic [3:0] MODE_LOAD_BIAS   = 4'd1;
    localparam logic [3:0] MODE_CLEAR       = 4'd2;
    localparam logic [3:0] MODE_PUSH        = 4'd3;
    localparam logic [3:0] MODE_POP         = 4'd4;
    localparam logic [3:0] MODE_REFRESH     = 4'd5;
    localparam logic [3:0] MODE_ADD         = 4'd6;
    localparam logic [3:0] MODE_SUB         = 4'd7;
    localparam logic [3:0] MODE_READ        = 4'd8;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

endpackage

`default_nettype wire

@@ src/nnue_accumulator_stack_engine_core.sv @@
// channel  dir  handshake            payload
// s_       in   s_tvalid / s_tready  s_tdata: mode, half_select, feature_index, lane_index,
//                                    load_value
// m_       out  m_tvalid / m_tready  m_tdata: read_value, status
//
// one item at a time; vectors move 32 lanes per cycle through one row of the accumulator ram
// load, clear, pop and rejected items skip the vector pass and go straight to the result
// add, subtract, refresh: one pass over the rows of the selected half; read: one row
// push: a pass over both halves of the top slot into the next slot, one ram row copied per cycle
// reset clears the sequencer, the stack pointer and the result valid flag; rams keep contents
// a stalled result holds the block in its last step until m_tready
`default_nettype none

module nnue_accumulator_stack_engine_core #(
    parameter int LANES       = 512,
    parameter int FEATURES    = 1024,
    parameter int STACK_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // mode[3:0], half_select[4], feature_index[14:5],
                                   // lane_index[23:15], load_value[39:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // read_value[15:0], status[17:16], zero[23:18]
);
    import nase_pkg::*;

    localparam int ROWS      = (LANES + CHUNK - 1) / CHUNK;
    localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int FW        = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int SW        = $clog2(STACK_DEPTH);
    localparam int WT_DEPTH  = 2 ** (FW + RW);
    localparam int ACC_DEPTH = 2 ** (SW + 1 + RW);
    localparam int BIAS_DEPTH = 2 ** RW;
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(STACK_DEPTH - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FINISH} state_t;

    state_t                 state_reg;
    logic [3:0]             op_reg;
    logic [FW-1:0]          feat_reg;
    logic [CHUNK_SHIFT-1:0] col_reg;
    logic [SW-1:0]          top_reg;
    logic [RW-1:0]          rd_row_reg;
    logic                   rd_half_reg;
    logic                   rd_done_reg;
    logic                   wr_pend_reg;
    logic [RW-1:0]          wr_row_reg;
    logic                   wr_half_reg;
    logic [1:0]             status_reg;
    logic [LANE_W-1:0]      rdval_reg;
    logic                   m_tvalid_reg;
    logic [23:0]            m_tdata_reg;

    logic [3:0]             in_mode;
    logic                   in_half;
    logic [9:0]             in_feat;
    logic [8:0]             in_lane;
    logic signed [15:0]     in_value;
    logic                   in_feat_ok;
    logic                   in_lane_ok;
    logic [RW-1:0]          in_row;
    logic [CHUNK_SHIFT-1:0] in_col;
    logic [1:0]             in_status;
    logic                   in_run;
    logic                   accept;

    row_t wt_mem   [WT_DEPTH];
    row_t bias_mem [BIAS_DEPTH];
    row_t acc_mem  [ACC_DEPTH];
    row_t wt_rd_reg;
    row_t bias_rd_reg;
    row_t acc_rd_reg;
    row_t sum_row;
    row_t acc_wdata;

    logic                   wt_we;
    logic                   bias_we;
    logic                   acc_we;
    logic [FW+RW-1:0]       wt_waddr;
    logic [FW+RW-1:0]       wt_raddr;
    logic [SW+RW:0]         acc_raddr;
    logic [SW+RW:0]         acc_waddr;
    logic [SW-1:0]          wr_slot;

    assign in_mode    = s_tdata[3:0];
    assign in_half    = s_tdata[4];
    assign in_feat    = s_tdata[14:5];
    assign in_lane    = s_tdata[23:15];
    assign in_value   = s_tdata[39:24];
    assign in_feat_ok = (32'(in_feat) < 32'(FEATURES));
    assign in_lane_ok = (32'(in_lane) < 32'(LANES));
    assign in_row     = RW'(in_lane >> CHUNK_SHIFT);
    assign in_col     = in_lane[CHUNK_SHIFT-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // status and vector pass decision for the item at the input
    always_comb begin
        in_status = STATUS_OK;
        in_run    = 1'b0;
        case (in_mode)
            MODE_PUSH: begin
                if (top_reg == LAST_SLOT) begin
                    in_status = STATUS_FULL;
                end else begin
                    in_run = 1'b1;
                end
            end
            MODE_POP: begin
                if (top_reg == '0) begin
                    in_status = STATUS_EMPTY;
                end
            end
            MODE_REFRESH: begin
                in_run = 1'b1;
            end
            MODE_ADD, MODE_SUB: begin
                in_run = in_feat_ok;
            end
            MODE_READ: begin
                in_run = in_lane_ok;
            end
            default: begin
            end
        endcase
    end

    // load ports
    assign wt_we    = accept && (in_mode == MODE_LOAD_WEIGHT) && in_feat_ok && in_lane_ok;
    assign bias_we  = accept && (in_mode == MODE_LOAD_BIAS) && in_lane_ok;
    assign wt_waddr = {FW'(in_feat), in_row};

    // row addresses, write side follows read side in the next cycle
    assign wt_raddr  = {feat_reg, rd_row_reg};
    assign acc_raddr = {top_reg, rd_half_reg, rd_row_reg};
    assign wr_slot   = (op_reg == MODE_PUSH) ? top_reg + 1'b1 : top_reg;
    assign acc_waddr = {wr_slot, wr_half_reg, wr_row_reg};
    assign acc_we    = (state_reg == ST_RUN) && wr_pend_reg && (op_reg != MODE_READ);

    // shared 32-lane add/subtract unit
    always_comb begin
        for (int i = 0; i < CHUNK; i++) begin
            if (op_reg == MODE_SUB) begin
                sum_row[i] = acc_rd_reg[i] - wt_rd_reg[i];
            end else begin
                sum_row[i] = acc_rd_reg[i] + wt_rd_reg[i];
            end
        end
        case (op_reg)
            MODE_PUSH:    acc_wdata = acc_rd_reg;
            MODE_REFRESH: acc_wdata = bias_rd_reg;
            default:      acc_wdata = sum_row;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wt_we) begin
            wt_mem[wt_waddr][in_col] <= in_value;
        end
        wt_rd_reg <= wt_mem[wt_raddr];
    end

    always_ff @(posedge aclk) begin
        if (bias_we) begin
            bias_mem[in_row][in_col] <= in_value;
        end
        bias_rd_reg <= bias_mem[rd_row_reg];
    end

    always_ff @(posedge aclk) begin
        if (acc_we) begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        acc_rd_reg <= acc_mem[acc_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            top_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tready && state_reg != ST_FINISH) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg      <= in_mode;
                        feat_reg    <= FW'(in_feat);
                        col_reg     <= in_col;
                        rd_half_reg <= (in_mode == MODE_PUSH) ? 1'b0 : in_half;
                        rd_row_reg  <= (in_mode == MODE_READ) ? in_row : '0;
                        rd_done_reg <= 1'b0;
                        wr_pend_reg <= 1'b0;
                        status_reg  <= in_status;
                        rdval_reg   <= '0;
                        state_reg   <= in_run ? ST_RUN : ST_FINISH;
                        case (in_mode)
                            MODE_CLEAR: begin
                                top_reg <= '0;
                            end
                            MODE_POP: begin
                                if (in_status == STATUS_OK) begin
                                    top_reg <= top_reg - 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_RUN: begin
                    wr_pend_reg <= !rd_done_reg;
                    wr_row_reg  <= rd_row_reg;
                    wr_half_reg <= rd_half_reg;
                    if (!rd_done_reg) begin
                        if (op_reg == MODE_READ) begin
                            rd_done_reg <= 1'b1;
                        end else if (rd_row_reg == LAST_ROW) begin
                            rd_row_reg <= '0;
                            if (op_reg == MODE_PUSH && !rd_half_reg) begin
                                rd_half_reg <= 1'b1;
                            end else begin
                                rd_done_reg <= 1'b1;
                            end
                        end else begin
                            rd_row_reg <= rd_row_reg + 1'b1;
                        end
                    end
                    if (wr_pend_reg && op_reg == MODE_READ) begin
                        rdval_reg <= acc_rd_reg[col_reg];
                    end
                    if (rd_done_reg && !wr_pend_reg) begin
                        if (op_reg == MODE_PUSH) begin
                            top_reg <= top_reg + 1'b1;
                        end
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'd0, status_reg, rdval_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/nase_checker.sv @@
`default_nettype none

module nase_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [39:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);
    import nase_pkg::*;

    // a held result keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // reset empties the result register
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one item in flight: ready drops after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    // status codes are only the three defined ones
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[17:16] == STATUS_OK || m_tdata[17:16] == STATUS_FULL ||
                      m_tdata[17:16] == STATUS_EMPTY))
        else $error("bad status code");

    // an ignored push or pop never carries a lane value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[17:16] != STATUS_OK |-> m_tdata[15:0] == 16'd0 &&
            m_tdata[23:18] == 6'd0)
        else $error("flagged item with nonzero data");

endmodule

bind nnue_accumulator_stack_engine_core nase_checker u_nase_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/nase_stack_checker.sv @@
`timescale 1ns / 1ps

package nase_tb_pkg;

    typedef struct packed {
        logic [15:0] load_value;
        logic [8:0]  lane_index;
        logic [9:0]  feature_index;
        logic        half_select;
        logic [3:0]  mode;
    } cmd_t;

    typedef struct packed {
        logic [5:0]  pad;
        logic [1:0]  status;
        logic [15:0] read_value;
    } reply_t;

endpackage

module nase_stack_checker #(
    parameter int LANES       = 512,
    parameter int FEATURES    = 1024,
    parameter int STACK_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // mode, half_select, feature_index, lane_index, load_value
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // read_value, status, zero
    output int          fail_count,
    output int          outstanding,
    output int          n_items,
    output int          n_reads,
    output int          n_full,
    output int          n_empty
);
    import nase_pkg::*;
    import nase_tb_pkg::*;

    bit [15:0]   weight_mem [FEATURES*LANES];
    bit [15:0]   bias_mem   [LANES];
    bit [15:0]   slot_mem   [STACK_DEPTH*2*LANES];
    int unsigned top_ptr;
    reply_t      expected_replies [$];

    function automatic reply_t apply_stack_op(cmd_t c);
        reply_t      r;
        int unsigned base;
        int unsigned col;
        r    = '0;
        base = (top_ptr * 2 + c.half_select) * LANES;
        col  = c.feature_index * LANES;
        case (c.mode)
            MODE_LOAD_WEIGHT: begin
                if (c.feature_index < FEATURES && c.lane_index < LANES)
                    weight_mem[col + c.lane_index] = c.load_value;
            end
            MODE_LOAD_BIAS: begin
                if (c.lane_index < LANES)
                    bias_mem[c.lane_index] = c.load_value;
            end
            MODE_CLEAR: top_ptr = 0;
            MODE_PUSH: begin
                if (top_ptr + 1 >= STACK_DEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    for (int i = 0; i < 2*LANES; i++)
                        slot_mem[(top_ptr+1)*2*LANES + i] = slot_mem[top_ptr*2*LANES + i];
                    top_ptr++;
                end
            end
            MODE_POP: begin
                if (top_ptr == 0)
                    r.status = STATUS_EMPTY;
                else
                    top_ptr--;
            end
            MODE_REFRESH: begin
                for (int i = 0; i < LANES; i++)
                    slot_mem[base + i] = bias_mem[i];
            end
            MODE_ADD, MODE_SUB: begin
                if (c.feature_index < FEATURES) begin
                    for (int i = 0; i < LANES; i++) begin
                        if (c.mode == MODE_SUB)
                            slot_mem[base + i] = slot_mem[base + i] - weight_mem[col + i];
                        else
                            slot_mem[base + i] = slot_mem[base + i] + weight_mem[col + i];
                    end
                end
            end
            MODE_READ: begin
                if (c.lane_index < LANES)
                    r.read_value = slot_mem[base + c.lane_index];
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        reply_t want;
        reply_t got;
        cmd_t   c;
        if (!aresetn) begin
            expected_replies.delete();
            top_ptr = 0;
            outstanding <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_replies.size() == 0) begin
                    $error("result with no item outstanding: tdata %h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_replies.pop_front();
                    if (got.read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               $signed(want.read_value), $signed(got.read_value));
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.pad !== want.pad) begin
                        $error("pad: expected %0d, got %0d", want.pad, got.pad);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                c    = s_tdata;
                want = apply_stack_op(c);
                expected_replies.push_back(want);
                n_items++;
                if (c.mode == MODE_READ)
                    n_reads++;
                if (want.status == STATUS_FULL)
                    n_full++;
                if (want.status == STATUS_EMPTY)
                    n_empty++;
            end
            outstanding <= expected_replies.size();
        end
    end

endmodule

@@ tb/tb_nnue_accumulator_stack_engine_core.sv @@
`timescale 1ns / 1ps

module tb_nnue_accumulator_stack_engine_core;

    import nase_pkg::*;
    import nase_tb_pkg::*;

    localparam int LANES        = 512;
    localparam int FEATURES     = 1024;
    localparam int STACK_DEPTH  = 64;
    localparam int RANDOM_ITEMS = 950;
    localparam int SEGMENT      = 200;
    localparam int DRAIN        = 100;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int WINDOW       = 32;

    localparam logic [3:0] MODE_LAST = 4'hf;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // mode, half_select, feature_index, lane_index, load_value
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // read_value, status, zero

    int fail_count;
    int outstanding;
    int n_items;
    int n_reads;
    int n_full;
    int n_empty;
    int cycle_count;

    // stimulus side view of what has been written
    bit [LANES-1:0] col_loaded [FEATURES];
    bit [LANES-1:0] bias_loaded;
    bit [LANES-1:0] half_mask  [STACK_DEPTH][2];
    int             gen_top;
    int             s_quiet;
    int             m_quiet;

    always #1 aclk = ~aclk;

    nnue_accumulator_stack_engine_core #(
        .LANES       (LANES),
        .FEATURES    (FEATURES),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    nase_stack_checker #(
        .LANES       (LANES),
        .FEATURES    (FEATURES),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .n_items     (n_items),
        .n_reads     (n_reads),
        .n_full      (n_full),
        .n_empty     (n_empty)
    );

    function automatic int pick_wait(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0)
            quiet_left = $urandom_range(10, 40);
        return $urandom_range(0, 8);
    endfunction

    // lanes at both ends of the vector
    function automatic logic [8:0] edge_lane(int k);
        return (k < WINDOW / 2) ? 9'(k) : 9'(LANES - WINDOW + k);
    endfunction

    function automatic cmd_t cmd(logic [3:0] m, logic h, logic [9:0] f, logic [8:0] l,
                                 logic [15:0] v);
        return '{load_value: v, lane_index: l, feature_index: f, half_select: h, mode: m};
    endfunction

    function automatic cmd_t any_cmd(logic [3:0] m);
        cmd_t c;
        c.mode          = m;
        c.half_select   = 1'($urandom_range(0, 1));
        c.feature_index = 10'($urandom_range(0, FEATURES-1));
        c.lane_index    = 9'($urandom_range(0, LANES-1));
        case ($urandom_range(0, 9))
            0:       c.load_value = 16'h8000;
            1:       c.load_value = 16'h7fff;
            2:       c.load_value = 16'h0000;
            3:       c.load_value = 16'hffff;
            default: c.load_value = 16'($urandom);
        endcase
        return c;
    endfunction

    task automatic send(cmd_t c);
        int gap;
        gap = pick_wait(s_quiet);
        case (c.mode)
            MODE_LOAD_WEIGHT: col_loaded[c.feature_index][c.lane_index] = 1'b1;
            MODE_LOAD_BIAS:   bias_loaded[c.lane_index] = 1'b1;
            MODE_CLEAR:       gen_top = 0;
            MODE_PUSH: begin
                if (gen_top + 1 < STACK_DEPTH) begin
                    half_mask[gen_top+1][0] = half_mask[gen_top][0];
                    half_mask[gen_top+1][1] = half_mask[gen_top][1];
                    gen_top++;
                end
            end
            MODE_POP: begin
                if (gen_top > 0)
                    gen_top--;
            end
            MODE_REFRESH: half_mask[gen_top][c.half_select] = bias_loaded;
            MODE_ADD, MODE_SUB: begin
                half_mask[gen_top][c.half_select] &= col_loaded[c.feature_index];
            end
            default: ;
        endcase
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    initial begin : stimulus
        int          preload_cols [3];
        cmd_t        c;
        logic [3:0]  m;
        logic        climb;
        int          roll;
        logic [15:0] fill;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // stack edges and unused modes before anything is written
        send(cmd(MODE_POP, 1'b0, 10'h000, 9'h000, 16'h0000));
        send(cmd(MODE_PUSH, 1'b1, 10'h3ff, 9'h1ff, 16'hffff));
        send(cmd(MODE_POP, 1'b1, 10'h3ff, 9'h1ff, 16'hffff));
        send(cmd(MODE_CLEAR, 1'b1, 10'h2aa, 9'h155, 16'h5555));
        for (int u = int'(MODE_READ) + 1; u <= int'(MODE_LAST); u++) begin
            fill = {16{u[0]}};
            send(cmd(4'(u), u[0], fill[9:0], fill[8:0], ~fill));
        end

        // bias and a few weight columns at the edge lanes so refresh and add have data
        for (int l = 0; l < WINDOW; l++) begin
            c = any_cmd(MODE_LOAD_BIAS);
            c.lane_index = edge_lane(l);
            send(c);
        end
        preload_cols = '{0, FEATURES-1, $urandom_range(1, FEATURES-2)};
        foreach (preload_cols[k]) begin
            for (int l = 0; l < WINDOW; l++) begin
                c = any_cmd(MODE_LOAD_WEIGHT);
                c.feature_index = 10'(preload_cols[k]);
                c.lane_index    = edge_lane(l);
                send(c);
            end
        end

        // extreme values at the edge lanes, then wrap through add and subtract
        send(cmd(MODE_LOAD_WEIGHT, 1'b0, 10'(FEATURES-1), 9'(LANES-1), 16'h7fff));
        send(cmd(MODE_LOAD_WEIGHT, 1'b1, 10'h000, 9'h000, 16'h8000));
        send(cmd(MODE_LOAD_BIAS, 1'b0, 10'h000, 9'h000, 16'h8000));
        send(cmd(MODE_LOAD_BIAS, 1'b1, 10'h3ff, 9'(LANES-1), 16'h7fff));
        send(cmd(MODE_REFRESH, 1'b0, 10'h3ff, 9'h1ff, 16'hffff));
        send(cmd(MODE_REFRESH, 1'b1, 10'h000, 9'h000, 16'h0000));
        send(cmd(MODE_READ, 1'b0, 10'h3ff, 9'h000, 16'hffff));
        send(cmd(MODE_READ, 1'b1, 10'h000, 9'(LANES-1), 16'h0000));
        send(cmd(MODE_ADD, 1'b0, 10'(FEATURES-1), 9'h000, 16'h0000));
        send(cmd(MODE_SUB, 1'b1, 10'h000, 9'h1ff, 16'hffff));
        send(cmd(MODE_READ, 1'b0, 10'h000, 9'(LANES-1), 16'h0000));
        send(cmd(MODE_READ, 1'b1, 10'h3ff, 9'h000, 16'hffff));
        send(cmd(MODE_PUSH, 1'b0, 10'h000, 9'h000, 16'h0000));
        send(cmd(MODE_ADD, 1'b0, 10'h000, 9'h000, 16'h0000));
        send(cmd(MODE_READ, 1'b0, 10'h000, 9'h000, 16'h0000));
        send(cmd(MODE_POP, 1'b0, 10'h000, 9'h000, 16'h0000));
        send(cmd(MODE_READ, 1'b0, 10'h000, 9'h000, 16'h0000));

        // random part: climbing and falling stretches so both stack ends are hit
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            climb = ((i / SEGMENT) % 2) == 0;
            roll  = $urandom_range(0, 99);
            if (roll < (climb ? 45 : 3))
                m = MODE_PUSH;
            else if (roll < (climb ? 48 : 25))
                m = MODE_POP;
            else if (!climb && roll < 28)
                m = MODE_CLEAR;
            else begin
                roll = $urandom_range(0, 99);
                if (roll < 12)
                    m = MODE_LOAD_WEIGHT;
                else if (roll < 18)
                    m = MODE_LOAD_BIAS;
                else if (roll < 30)
                    m = MODE_REFRESH;
                else if (roll < 50)
                    m = MODE_ADD;
                else if (roll < 65)
                    m = MODE_SUB;
                else if (roll < 96)
                    m = MODE_READ;
                else
                    m = 4'($urandom_range(int'(MODE_READ) + 1, int'(MODE_LAST)));
            end
            c = any_cmd(m);
            if (c.mode == MODE_READ) begin
                c.lane_index = edge_lane($urandom_range(0, WINDOW-1));
                if (!half_mask[gen_top][c.half_select][c.lane_index])
                    c.mode = MODE_REFRESH;
            end
            if ((c.mode == MODE_LOAD_WEIGHT || c.mode == MODE_LOAD_BIAS) &&
                $urandom_range(0, 1) == 0)
                c.lane_index = edge_lane($urandom_range(0, WINDOW-1));
            if (c.mode == MODE_ADD || c.mode == MODE_SUB ||
                (c.mode == MODE_LOAD_WEIGHT && $urandom_range(0, 1) == 0))
                c.feature_index = 10'(preload_cols[$urandom_range(0, 2)]);
            send(c);
        end
        s_tvalid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        $display("checked %0d results: %0d lane reads, %0d full-stack pushes, %0d empty pops",
                 n_items, n_reads, n_full, n_empty);
        $display("bias lanes loaded: %0d", $countones(bias_loaded));
        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : result_sink
        int stall;
        @(posedge aclk);
        forever begin
            stall = pick_wait(m_quiet);
            if (stall > 0) begin
                m_tready <= 1'b0;
                @(posedge aclk);
                while (!m_tvalid) @(posedge aclk);
                repeat (stall - 1) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

endmodule

@@ files.f @@
src/nase_pkg.sv
src/nnue_accumulator_stack_engine_core.sv
src/nase_checker.sv
tb/nase_stack_checker.sv
tb/tb_nnue_accumulator_stack_engine_core.sv
